// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int W = 64;
	localparam int CW = $clog2(W);

	typedef logic [W-1:0] word_t;
	typedef logic [1:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_MUL = 2'd0;
	localparam mode_t MODE_DIV = 2'd1;
	localparam mode_t MODE_GCD = 2'd2;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_OVF  = 2'd1;
	localparam status_t ST_ZDEN = 2'd2;
	localparam status_t ST_DIV0 = 2'd3;

	localparam logic [2:0] OP_NORM = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	localparam word_t MIN_VAL = {1'b1, {(W-1){1'b0}}};
	localparam word_t MAX_VAL = {1'b0, {(W-1){1'b1}}};

	typedef struct packed {
		logic  go;
		mode_t mode;
		word_t x;
		word_t y;
	} rau_req_t;

	typedef struct packed {
		logic  done;
		word_t hi;
		word_t lo;
	} rau_rsp_t;

endpackage
`default_nettype wire

// File: rtl/rau_iter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_iter
// Shared iterative unit: shift-add multiply, restoring divide and binary gcd,
// one step per cycle.
// ----------------------------------------------------------------------------
module rau_iter import rau_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rau_req_t req,
	output rau_rsp_t      rsp
);

	logic              run_q;
	logic              done_q;
	mode_t             mode_q;
	logic [2*W-1:0]    p_q;
	word_t             d_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     k_q;

	word_t           a;
	word_t           b;
	logic [W:0]      msum;
	logic [W:0]      dtry;
	logic [W:0]      dab;
	logic [W:0]      dba;

	assign a    = p_q[2*W-1:W];
	assign b    = p_q[W-1:0];
	assign msum = {1'b0, a} + (p_q[0] ? {1'b0, d_q} : {(W+1){1'b0}});
	assign dtry = p_q[2*W-1:W-1] - {1'b0, d_q};
	assign dab  = {1'b0, a} - {1'b0, b};
	assign dba  = {1'b0, b} - {1'b0, a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				mode_q <= req.mode;
				cnt_q  <= '0;
				k_q    <= '0;
				case (req.mode)
					MODE_GCD: begin
						if (req.x == '0) begin
							p_q    <= {req.y, {W{1'b0}}};
							done_q <= 1'b1;
						end else begin
							p_q   <= {req.x, req.y};
							run_q <= 1'b1;
						end
					end
					MODE_DIV: begin
						p_q   <= {{W{1'b0}}, req.x};
						d_q   <= req.y;
						run_q <= 1'b1;
					end
					default: begin
						p_q   <= {{W{1'b0}}, req.y};
						d_q   <= req.x;
						run_q <= 1'b1;
					end
				endcase
			end else if (run_q) begin
				case (mode_q)
					MODE_GCD: begin
						if (b == '0) begin
							if (k_q != '0) begin
								p_q <= {a[W-2:0], 1'b0, b};
								k_q <= k_q - 1'b1;
							end else begin
								run_q  <= 1'b0;
								done_q <= 1'b1;
							end
						end else if (!a[0] && !b[0]) begin
							p_q <= {1'b0, a[W-1:1], 1'b0, b[W-1:1]};
							k_q <= k_q + 1'b1;
						end else if (!a[0]) begin
							p_q <= {1'b0, a[W-1:1], b};
						end else if (!b[0]) begin
							p_q <= {a, 1'b0, b[W-1:1]};
						end else if (!dab[W]) begin
							p_q <= {b, dab[W-1:0]};
						end else begin
							p_q <= {a, dba[W-1:0]};
						end
					end
					MODE_DIV: begin
						if (!dtry[W]) begin
							p_q <= {dtry[W-1:0], p_q[W-2:0], 1'b1};
						end else begin
							p_q <= {p_q[2*W-2:0], 1'b0};
						end
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CW'(W-1)) begin
							run_q  <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						p_q   <= {msum, p_q[W-1:1]};
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CW'(W-1)) begin
							run_q  <= 1'b0;
							done_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.hi   = p_q[2*W-1:W];
	assign rsp.lo   = p_q[W-1:0];

endmodule
`default_nettype wire

// File: rtl/rational_arith_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// Normalize, add, subtract, multiply and divide of 64-bit signed fractions.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result word appears for one cycle with res_valid, and the next
// start may come in that same cycle. Multiply, divide and gcd run one step
// per cycle in a single shared iterative unit; the final add or subtract is
// done directly in the core. Each reduction of a fraction is a binary gcd
// followed by two divides by the gcd; each cross product is one multiply.
// A normalize is one reduction, a full add or subtract three reductions and
// three products. The receiver cannot stall the result.
module rational_arith_unit_core import rau_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         op,
	input  wire logic signed [63:0] a_num,
	input  wire logic signed [63:0] a_den,
	input  wire logic signed [63:0] b_num,
	input  wire logic signed [63:0] b_den,
	output logic                    res_valid,
	output logic signed [63:0]      res_num,
	output logic [62:0]             res_den,
	output logic [1:0]              status
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_NCHK  = 7'b0000010,
		S_NGCD  = 7'b0000100,
		S_NDIVN = 7'b0001000,
		S_NDIVD = 7'b0010000,
		S_MUL   = 7'b0100000,
		S_ADD   = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		PH_A = 2'd0,
		PH_B = 2'd1,
		PH_R = 2'd2
	} phase_t;

	state_t     state_q;
	phase_t     phase_q;
	logic [2:0] op_q;
	logic       go_q;
	logic       ovf_q;
	logic [1:0] mi_q;
	word_t      an_q, ad_q, bn_q, bd_q;
	word_t      fn_q, fd_q;
	word_t      nmag_q, nden_q, g_q, qn_q;
	logic       nsgn_q;
	word_t      px_q, py_q, pd_q;

	rau_req_t   req;
	rau_rsp_t   rsp;

	logic       is_as;
	word_t      ma, mb, mma, mmb;
	logic       rneg;
	logic       ovf_p;
	word_t      pval;
	word_t      on_w;
	word_t      cn, cd;
	word_t      sum_w;
	logic       sum_ovf;

	assign is_as = (op_q == OP_ADD) || (op_q == OP_SUB);

	always_comb begin
		ma = an_q;
		mb = bd_q;
		case (mi_q)
			2'd0: begin
				ma = an_q;
				mb = (op_q == OP_MUL) ? bn_q : bd_q;
			end
			2'd1: begin
				ma = bn_q;
				mb = ad_q;
			end
			default: begin
				ma = ad_q;
				mb = (op_q == OP_DIV) ? bn_q : bd_q;
			end
		endcase
	end

	assign mma   = ma[W-1] ? (~ma + 1'b1) : ma;
	assign mmb   = mb[W-1] ? (~mb + 1'b1) : mb;
	assign rneg  = (ma[W-1] != mb[W-1]) && (ma != '0) && (mb != '0);
	assign ovf_p = (rsp.hi != '0) || (rsp.lo > (rneg ? MIN_VAL : MAX_VAL));
	assign pval  = rneg ? (~rsp.lo + 1'b1) : rsp.lo;
	assign on_w  = nsgn_q ? (~qn_q + 1'b1) : qn_q;
	assign cn    = fd_q[W-1] ? (~fn_q + 1'b1) : fn_q;
	assign cd    = fd_q[W-1] ? (~fd_q + 1'b1) : fd_q;
	assign sum_w = (op_q == OP_SUB) ? (px_q - py_q) : (px_q + py_q);
	assign sum_ovf = (op_q == OP_SUB)
		? ((px_q[W-1] != py_q[W-1]) && (sum_w[W-1] != px_q[W-1]))
		: ((px_q[W-1] == py_q[W-1]) && (sum_w[W-1] != px_q[W-1]));

	always_comb begin
		req.go   = go_q;
		req.mode = MODE_MUL;
		req.x    = mma;
		req.y    = mmb;
		unique case (state_q)
			S_NGCD: begin
				req.mode = MODE_GCD;
				req.x    = nmag_q;
				req.y    = nden_q;
			end
			S_NDIVN: begin
				req.mode = MODE_DIV;
				req.x    = nmag_q;
				req.y    = g_q;
			end
			S_NDIVD: begin
				req.mode = MODE_DIV;
				req.x    = nden_q;
				req.y    = g_q;
			end
			default: begin
			end
		endcase
	end

	rau_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_A;
			go_q      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			go_q      <= 1'b0;
			res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						fn_q    <= a_num;
						fd_q    <= a_den;
						bn_q    <= b_num;
						bd_q    <= b_den;
						phase_q <= PH_A;
						state_q <= S_NCHK;
					end
				end
				S_NCHK: begin
					if (fd_q == '0) begin
						res_valid <= 1'b1;
						status    <= ST_ZDEN;
						res_num   <= '0;
						res_den   <= '0;
						state_q   <= S_IDLE;
					end else if (fd_q[W-1] && (fn_q == MIN_VAL || fd_q == MIN_VAL)) begin
						res_valid <= 1'b1;
						status    <= ST_OVF;
						res_num   <= '0;
						res_den   <= '0;
						state_q   <= S_IDLE;
					end else begin
						nsgn_q  <= cn[W-1];
						nmag_q  <= cn[W-1] ? (~cn + 1'b1) : cn;
						nden_q  <= cd;
						go_q    <= 1'b1;
						state_q <= S_NGCD;
					end
				end
				S_NGCD: begin
					if (rsp.done) begin
						g_q     <= rsp.hi;
						go_q    <= 1'b1;
						state_q <= S_NDIVN;
					end
				end
				S_NDIVN: begin
					if (rsp.done) begin
						qn_q    <= rsp.lo;
						go_q    <= 1'b1;
						state_q <= S_NDIVD;
					end
				end
				S_NDIVD: begin
					if (rsp.done) begin
						if (phase_q == PH_A && op_q >= OP_ADD && op_q <= OP_DIV) begin
							an_q    <= on_w;
							ad_q    <= rsp.lo;
							fn_q    <= bn_q;
							fd_q    <= bd_q;
							phase_q <= PH_B;
							state_q <= S_NCHK;
						end else if (phase_q == PH_B) begin
							bn_q <= on_w;
							bd_q <= rsp.lo;
							if (op_q == OP_DIV && on_w == '0) begin
								res_valid <= 1'b1;
								status    <= ST_DIV0;
								res_num   <= '0;
								res_den   <= '0;
								state_q   <= S_IDLE;
							end else begin
								mi_q    <= 2'd0;
								ovf_q   <= 1'b0;
								go_q    <= 1'b1;
								state_q <= S_MUL;
							end
						end else begin
							res_valid <= 1'b1;
							status    <= ST_OK;
							res_num   <= on_w;
							res_den   <= rsp.lo[W-2:0];
							state_q   <= S_IDLE;
						end
					end
				end
				S_MUL: begin
					if (rsp.done) begin
						ovf_q <= ovf_q | ovf_p;
						case (mi_q)
							2'd0: px_q <= pval;
							2'd1: py_q <= pval;
							default: pd_q <= pval;
						endcase
						if (mi_q == 2'd0) begin
							mi_q <= is_as ? 2'd1 : 2'd2;
							go_q <= 1'b1;
						end else if (mi_q == 2'd1) begin
							mi_q <= 2'd2;
							go_q <= 1'b1;
						end else if (is_as) begin
							state_q <= S_ADD;
						end else if (ovf_q || ovf_p) begin
							res_valid <= 1'b1;
							status    <= ST_OVF;
							res_num   <= '0;
							res_den   <= '0;
							state_q   <= S_IDLE;
						end else begin
							fn_q    <= px_q;
							fd_q    <= pval;
							phase_q <= PH_R;
							state_q <= S_NCHK;
						end
					end
				end
				S_ADD: begin
					if (ovf_q || sum_ovf) begin
						res_valid <= 1'b1;
						status    <= ST_OVF;
						res_num   <= '0;
						res_den   <= '0;
						state_q   <= S_IDLE;
					end else begin
						fn_q    <= sum_w;
						fd_q    <= pd_q;
						phase_q <= PH_R;
						state_q <= S_NCHK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/rau_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_chk
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_chk import rau_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               res_valid,
	input wire logic signed [63:0] res_num,
	input wire logic [62:0]        res_den,
	input wire logic [1:0]         status
);

	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !busy) else $error("result word while busy");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> res_valid) else $error("busy dropped without a result word");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> res_num == '0 && res_den == '0)
		else $error("error result not zero");

	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_OK |-> res_den != '0)
		else $error("good result with zero denominator");

endmodule

bind rational_arith_unit_core rau_chk u_rau_chk (.*);
`default_nettype wire
